// File: sv/ptns_pkg.sv
`timescale 1ns / 1ps
// Package with the widths, types and helper functions of the planar turn neighbor select block.
package ptns_pkg;

	localparam int ID_BITS    = 16;
	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int PERP_BITS  = PROD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [PERP_BITS-1:0]  perp_t;
	typedef logic        [ID_BITS-1:0]    id_t;

	// The unit step along negative y, used as the incoming direction without a previous vertex.
	localparam diff_t NO_PREV_DIR_Y = -diff_t'(1 << FRAC_BITS);

	typedef struct packed {
		coord_t cur_x;
		coord_t cur_y;
		coord_t prev_x;
		coord_t prev_y;
		logic   has_prev;
		id_t    prev_id;
		logic   nbr_present;
		id_t    nbr_id;
		coord_t nbr_x;
		coord_t nbr_y;
		logic   want_ccw;
		logic   last_nbr;
	} in_word_t;

	typedef struct packed {
		logic found;
		id_t  chosen_id;
	} out_word_t;

	typedef struct packed {
		logic  have;
		id_t   id;
		diff_t dx;
		diff_t dy;
		logic  convex;
	} cand_t;

	function automatic diff_t coord_diff(input coord_t a, input coord_t b);
		diff_t wa;
		diff_t wb;
		wa = {a[COORD_BITS-1], a};
		wb = {b[COORD_BITS-1], b};
		return wa - wb;
	endfunction

endpackage

// File: sv/ptns_in_if.sv
`timescale 1ns / 1ps
// Interface for the neighbor input channel with its handshake and payload.
interface ptns_in_if;
	logic             valid;
	logic             ready;
	ptns_pkg::coord_t cur_x;
	ptns_pkg::coord_t cur_y;
	ptns_pkg::coord_t prev_x;
	ptns_pkg::coord_t prev_y;
	logic             has_prev;
	ptns_pkg::id_t    prev_id;
	logic             nbr_present;
	ptns_pkg::id_t    nbr_id;
	ptns_pkg::coord_t nbr_x;
	ptns_pkg::coord_t nbr_y;
	logic             want_ccw;
	logic             last_nbr;

	modport source(
		output valid, cur_x, cur_y, prev_x, prev_y, has_prev, prev_id,
			nbr_present, nbr_id, nbr_x, nbr_y, want_ccw, last_nbr,
		input ready
	);
	modport sink(
		input valid, cur_x, cur_y, prev_x, prev_y, has_prev, prev_id,
			nbr_present, nbr_id, nbr_x, nbr_y, want_ccw, last_nbr,
		output ready
	);
endinterface

// File: sv/ptns_out_if.sv
`timescale 1ns / 1ps
// Interface for the result channel with its handshake and payload.
interface ptns_out_if;
	logic          valid;
	logic          ready;
	logic          found;
	ptns_pkg::id_t chosen_id;

	modport source(output valid, found, chosen_id, input ready);
	modport sink(input valid, found, chosen_id, output ready);
endinterface

// File: sv/planar_turn_neighbor_select_core.sv
`timescale 1ns / 1ps
// Top level of the planar turn neighbor select block.
//
//   channel   dir   word                                  count
//   nbr_in    in    one neighbor of the current vertex    one per neighbor
//   res_out   out   found flag and chosen neighbor id     one per last_nbr word
//
// Each word is registered, then evaluated and folded into the candidate, so one
// word is taken every cycle unless a last_nbr word waits on a stalled result
// register, which holds that word and those behind it; others keep flowing.
// Results are registered; the candidate state feeds back combinationally.
// Reset clears the input stage, the candidate and the result register.
module planar_turn_neighbor_select_core (
	input  logic      clk,
	input  logic      arst_n,
	ptns_in_if.sink   nbr_in,
	ptns_out_if.source res_out
);

	logic                valid_s1;
	ptns_pkg::in_word_t  word_s1;
	ptns_pkg::cand_t     cand_q;
	ptns_pkg::cand_t     cand_next;
	ptns_pkg::out_word_t result;
	logic                res_free;
	logic                advance;

	assign advance      = valid_s1 && (!word_s1.last_nbr || res_free);
	assign nbr_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (nbr_in.ready) begin
			valid_s1 <= nbr_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (nbr_in.ready && nbr_in.valid) begin
			word_s1.cur_x       <= nbr_in.cur_x;
			word_s1.cur_y       <= nbr_in.cur_y;
			word_s1.prev_x      <= nbr_in.prev_x;
			word_s1.prev_y      <= nbr_in.prev_y;
			word_s1.has_prev    <= nbr_in.has_prev;
			word_s1.prev_id     <= nbr_in.prev_id;
			word_s1.nbr_present <= nbr_in.nbr_present;
			word_s1.nbr_id      <= nbr_in.nbr_id;
			word_s1.nbr_x       <= nbr_in.nbr_x;
			word_s1.nbr_y       <= nbr_in.nbr_y;
			word_s1.want_ccw    <= nbr_in.want_ccw;
			word_s1.last_nbr    <= nbr_in.last_nbr;
		end
	end

	ptns_turn_eval u_eval (
		.word      (word_s1),
		.cand      (cand_q),
		.cand_next (cand_next)
	);

	// The candidate returns to its cleared state after the last word of a query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (advance) begin
			cand_q <= word_s1.last_nbr ? '0 : cand_next;
		end
	end

	assign result.found     = cand_next.have;
	assign result.chosen_id = cand_next.have ? cand_next.id : '0;

	ptns_result_reg u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && word_s1.last_nbr),
		.word    (result),
		.free    (res_free),
		.res_out (res_out)
	);

endmodule

// File: sv/ptns_turn_eval.sv
`timescale 1ns / 1ps
// Turn evaluation: two exact perp-dot products and the candidate replacement rule.
module ptns_turn_eval (
	input  ptns_pkg::in_word_t word,
	input  ptns_pkg::cand_t    cand,
	output ptns_pkg::cand_t    cand_next
);

	ptns_pkg::diff_t dir_x;
	ptns_pkg::diff_t dir_y;
	ptns_pkg::diff_t adj_x;
	ptns_pkg::diff_t adj_y;
	ptns_pkg::prod_t m_ca_0;
	ptns_pkg::prod_t m_ca_1;
	ptns_pkg::prod_t m_ad_0;
	ptns_pkg::prod_t m_ad_1;
	ptns_pkg::perp_t p_cand_adj;
	ptns_pkg::perp_t p_adj_dir;
	logic            ca_pos;
	logic            ca_neg;
	logic            ad_pos;
	logic            ad_neg;
	logic            skip;
	logic            rule;
	logic            take;

	always_comb begin
		if (word.has_prev) begin
			dir_x = ptns_pkg::coord_diff(word.prev_x, word.cur_x);
			dir_y = ptns_pkg::coord_diff(word.prev_y, word.cur_y);
		end else begin
			dir_x = '0;
			dir_y = ptns_pkg::NO_PREV_DIR_Y;
		end
	end

	assign adj_x = ptns_pkg::coord_diff(word.nbr_x, word.cur_x);
	assign adj_y = ptns_pkg::coord_diff(word.nbr_y, word.cur_y);

	assign m_ca_0 = cand.dx * adj_y;
	assign m_ca_1 = cand.dy * adj_x;
	assign m_ad_0 = adj_x * dir_y;
	assign m_ad_1 = adj_y * dir_x;

	assign p_cand_adj = ptns_pkg::perp_t'(m_ca_0) - ptns_pkg::perp_t'(m_ca_1);
	assign p_adj_dir  = ptns_pkg::perp_t'(m_ad_0) - ptns_pkg::perp_t'(m_ad_1);

	assign ca_neg = p_cand_adj[ptns_pkg::PERP_BITS-1];
	assign ca_pos = !ca_neg && (p_cand_adj != '0);
	assign ad_neg = p_adj_dir[ptns_pkg::PERP_BITS-1];
	assign ad_pos = !ad_neg && (p_adj_dir != '0);

	assign skip = !word.nbr_present || (word.has_prev && (word.nbr_id == word.prev_id));

	// The reversed products of the rule table are the negations of these two.
	always_comb begin
		case ({word.want_ccw, cand.convex})
			2'b00:   rule = ad_pos || ca_pos;
			2'b01:   rule = ca_pos && ad_pos;
			2'b10:   rule = ca_neg && ad_neg;
			2'b11:   rule = ad_neg || ca_neg;
			default: rule = 1'b0;
		endcase
	end

	assign take = !skip && (!cand.have || ((word.nbr_id != cand.id) && rule));

	always_comb begin
		if (take) begin
			cand_next.have   = 1'b1;
			cand_next.id     = word.nbr_id;
			cand_next.dx     = adj_x;
			cand_next.dy     = adj_y;
			cand_next.convex = !ad_neg;
		end else begin
			cand_next = cand;
		end
	end

endmodule

// File: sv/ptns_result_reg.sv
`timescale 1ns / 1ps
// Output register that holds one result word until the sink takes it.
module ptns_result_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ptns_pkg::out_word_t word,
	output logic                free,
	ptns_out_if.source          res_out
);

	logic                valid_q;
	ptns_pkg::out_word_t word_q;

	assign free = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			word_q <= word;
		end
	end

	assign res_out.valid     = valid_q;
	assign res_out.found     = word_q.found;
	assign res_out.chosen_id = word_q.chosen_id;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the planar turn neighbor select core with directed and random queries.
module tb_top;

	typedef struct {
		ptns_pkg::in_word_t word;
		bit                 drain_first;
	} queued_word_t;

	localparam int U         = 1 << ptns_pkg::FRAC_BITS;
	localparam int COORD_MAX = (1 << (ptns_pkg::COORD_BITS - 1)) - 1;
	localparam int COORD_MIN = -(1 << (ptns_pkg::COORD_BITS - 1));
	localparam int ID_MAX    = (1 << ptns_pkg::ID_BITS) - 1;

	logic clk;
	logic arst_n;

	ptns_in_if  nbr_bus();
	ptns_out_if res_bus();

	planar_turn_neighbor_select_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.nbr_in(nbr_bus),
		.res_out(res_bus)
	);

	queued_word_t        pending_words[$];
	ptns_pkg::out_word_t expected_picks[$];
	ptns_pkg::in_word_t  held_word;
	int                  words_accepted;
	int                  words_total;
	int                  idle_left;
	int                  stall_left;
	bit                  tail_phase;
	bit                  mismatch_seen;
	logic [31:0]         cycle_count;

	// Running selection for the query in progress.
	bit            sel_have;
	ptns_pkg::id_t sel_id;
	longint        sel_dx;
	longint        sel_dy;
	bit            sel_convex;

	function automatic longint perp_dot(input longint ax, input longint ay,
		input longint bx, input longint by);
		return ax * by - ay * bx;
	endfunction

	// Folds one neighbor word into the selection; returns 1 with the pick on a last word.
	function automatic bit advance_selection(input ptns_pkg::in_word_t w,
		output ptns_pkg::out_word_t pick);
		longint cx;
		longint cy;
		longint dir_x;
		longint dir_y;
		longint ax;
		longint ay;
		bit     take;
		cx = longint'(w.cur_x);
		cy = longint'(w.cur_y);
		if (w.has_prev) begin
			dir_x = longint'(w.prev_x) - cx;
			dir_y = longint'(w.prev_y) - cy;
		end else begin
			dir_x = 0;
			dir_y = longint'(ptns_pkg::NO_PREV_DIR_Y);
		end
		if (w.nbr_present && !(w.has_prev && w.nbr_id == w.prev_id)) begin
			ax = longint'(w.nbr_x) - cx;
			ay = longint'(w.nbr_y) - cy;
			take = 1'b0;
			if (!sel_have) begin
				take = 1'b1;
			end else if (w.nbr_id != sel_id) begin
				if (!w.want_ccw) begin
					if (sel_convex)
						take = perp_dot(sel_dx, sel_dy, ax, ay) > 0 &&
							perp_dot(ax, ay, dir_x, dir_y) > 0;
					else
						take = perp_dot(dir_x, dir_y, ax, ay) < 0 ||
							perp_dot(ax, ay, sel_dx, sel_dy) < 0;
				end else begin
					if (sel_convex)
						take = perp_dot(dir_x, dir_y, ax, ay) > 0 ||
							perp_dot(ax, ay, sel_dx, sel_dy) > 0;
					else
						take = perp_dot(sel_dx, sel_dy, ax, ay) < 0 &&
							perp_dot(ax, ay, dir_x, dir_y) < 0;
				end
			end
			if (take) begin
				sel_have   = 1'b1;
				sel_id     = w.nbr_id;
				sel_dx     = ax;
				sel_dy     = ay;
				sel_convex = perp_dot(ax, ay, dir_x, dir_y) >= 0;
			end
		end
		pick = '0;
		if (!w.last_nbr)
			return 1'b0;
		pick.found     = sel_have;
		pick.chosen_id = sel_have ? sel_id : '0;
		sel_have   = 1'b0;
		sel_id     = '0;
		sel_dx     = 0;
		sel_dy     = 0;
		sel_convex = 1'b0;
		return 1'b1;
	endfunction

	function automatic void add_word(input int cx, input int cy, input bit hp, input int px,
		input int py, input int pid, input bit present, input int nid, input int nx,
		input int ny, input bit ccw, input bit is_last, input bit drain);
		queued_word_t q;
		q.word.cur_x       = ptns_pkg::coord_t'(cx);
		q.word.cur_y       = ptns_pkg::coord_t'(cy);
		q.word.prev_x      = ptns_pkg::coord_t'(px);
		q.word.prev_y      = ptns_pkg::coord_t'(py);
		q.word.has_prev    = hp;
		q.word.prev_id     = ptns_pkg::id_t'(pid);
		q.word.nbr_present = present;
		q.word.nbr_id      = ptns_pkg::id_t'(nid);
		q.word.nbr_x       = ptns_pkg::coord_t'(nx);
		q.word.nbr_y       = ptns_pkg::coord_t'(ny);
		q.word.want_ccw    = ccw;
		q.word.last_nbr    = is_last;
		q.drain_first      = drain;
		pending_words.push_back(q);
	endfunction

	function automatic int full_coord();
		return int'($urandom_range(0, (1 << ptns_pkg::COORD_BITS) - 1)) + COORD_MIN;
	endfunction

	function automatic int pick_base();
		case ($urandom_range(0, 7))
			0: begin
				return full_coord();
			end
			1: begin
				case ($urandom_range(0, 3))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return 0;
					default: return -1;
				endcase
			end
			default: begin
				return (int'($urandom_range(0, 64)) - 32) * U;
			end
		endcase
	endfunction

	function automatic int pick_offset();
		case ($urandom_range(0, 9))
			0: return full_coord();
			1: return int'($urandom_range(0, 2 * U - 1)) - U;
			default: return (int'($urandom_range(0, 8)) - 4) * U;
		endcase
	endfunction

	function automatic int pick_id();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(0, ID_MAX));
		return int'($urandom_range(0, 7));
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			cycle_count <= '0;
		else
			cycle_count <= cycle_count + 1;
	end

	// Sender: presents queued words with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		queued_word_t        head;
		ptns_pkg::out_word_t pick;
		if (!arst_n) begin
			nbr_bus.valid <= 1'b0;
			{nbr_bus.cur_x, nbr_bus.cur_y, nbr_bus.prev_x, nbr_bus.prev_y, nbr_bus.has_prev,
				nbr_bus.prev_id, nbr_bus.nbr_present, nbr_bus.nbr_id, nbr_bus.nbr_x,
				nbr_bus.nbr_y, nbr_bus.want_ccw, nbr_bus.last_nbr} <= '0;
			held_word  <= '0;
			tail_phase <= 1'b0;
			idle_left = 0;
		end else begin
			if (nbr_bus.valid && nbr_bus.ready) begin
				words_accepted++;
				if (advance_selection(held_word, pick))
					expected_picks.push_back(pick);
			end
			tail_phase <= pending_words.size() < 100;
			if (!nbr_bus.valid || nbr_bus.ready) begin
				if (idle_left > 0) begin
					idle_left--;
					nbr_bus.valid <= 1'b0;
				end else if (pending_words.size() == 0) begin
					nbr_bus.valid <= 1'b0;
				end else if (pending_words[0].drain_first && expected_picks.size() != 0) begin
					nbr_bus.valid <= 1'b0;
				end else if (!tail_phase && cycle_count[8:7] != 2'b11 &&
					$urandom_range(0, 11) == 0) begin
					idle_left = $urandom_range(0, 18);
					nbr_bus.valid <= 1'b0;
				end else begin
					head = pending_words.pop_front();
					{nbr_bus.cur_x, nbr_bus.cur_y, nbr_bus.prev_x, nbr_bus.prev_y,
						nbr_bus.has_prev, nbr_bus.prev_id, nbr_bus.nbr_present,
						nbr_bus.nbr_id, nbr_bus.nbr_x, nbr_bus.nbr_y, nbr_bus.want_ccw,
						nbr_bus.last_nbr} <= head.word;
					held_word     <= head.word;
					nbr_bus.valid <= 1'b1;
				end
			end
		end
	end

	// Receiver: checks each result word and stalls in random bursts.
	always @(posedge clk or negedge arst_n) begin
		ptns_pkg::out_word_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_picks.size() == 0) begin
					$error("unexpected result word: found %0d, chosen_id %0d",
						res_bus.found, res_bus.chosen_id);
					mismatch_seen = 1'b1;
				end else begin
					want = expected_picks.pop_front();
					if (res_bus.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, res_bus.found);
						mismatch_seen = 1'b1;
					end
					if (res_bus.chosen_id !== want.chosen_id) begin
						$error("chosen_id: expected %0d, actual %0d",
							want.chosen_id, res_bus.chosen_id);
						mismatch_seen = 1'b1;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (!tail_phase && cycle_count[8:7] != 2'b11 &&
				$urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 18);
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		int cx;
		int cy;
		int px;
		int py;
		int pid;
		int len;
		int i;
		bit hp;
		bit ccw;
		bit noise;
		bit drain;
		bit first_query;
		bit is_last;
		arst_n        = 1'b0;
		nbr_bus.valid = 1'b0;
		res_bus.ready = 1'b0;
		{nbr_bus.cur_x, nbr_bus.cur_y, nbr_bus.prev_x, nbr_bus.prev_y, nbr_bus.has_prev,
			nbr_bus.prev_id, nbr_bus.nbr_present, nbr_bus.nbr_id, nbr_bus.nbr_x,
			nbr_bus.nbr_y, nbr_bus.want_ccw, nbr_bus.last_nbr} = '0;
		words_accepted = 0;
		mismatch_seen  = 1'b0;
		sel_have       = 1'b0;
		sel_id         = '0;
		sel_dx         = 0;
		sel_dy         = 0;
		sel_convex     = 1'b0;

		// An empty query.
		add_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
		// Clockwise and counterclockwise with the default direction.
		add_word(0, 0, 0, 0, 0, 0, 1, 1, U, 0, 0, 0, 0);
		add_word(0, 0, 0, 0, 0, 0, 1, 2, -U, 0, 0, 0, 0);
		add_word(0, 0, 0, 0, 0, 0, 1, 3, 0, U, 0, 1, 0);
		add_word(0, 0, 0, 0, 0, 0, 1, 1, U, 0, 1, 0, 0);
		add_word(0, 0, 0, 0, 0, 0, 1, 2, -U, 0, 1, 0, 0);
		add_word(0, 0, 0, 0, 0, 0, 1, 3, 0, U, 1, 1, 0);
		// The previous vertex and a repeat of the candidate are skipped.
		add_word(0, 0, 1, U, U, 7, 1, 7, U, -U, 0, 0, 0);
		add_word(0, 0, 1, U, U, 7, 1, 8, -U, 0, 0, 0, 0);
		add_word(0, 0, 1, U, U, 7, 1, 8, 0, U, 0, 0, 0);
		add_word(0, 0, 1, U, U, 7, 1, 9, 2 * U, 2 * U, 0, 1, 0);
		// Without a previous vertex its id is not skipped; an empty word ends the query.
		add_word(0, 0, 0, U, 0, 5, 1, 5, 0, U, 0, 0, 0);
		add_word(0, 0, 0, U, 0, 5, 0, 0, 0, 0, 0, 1, 0);
		// The only neighbor is the previous vertex.
		add_word(0, 0, 1, U, 0, ID_MAX, 1, ID_MAX, U, 0, 1, 1, 0);
		// Extreme coordinates and ids.
		add_word(COORD_MIN, COORD_MIN, 1, COORD_MAX, COORD_MAX, 0, 1, ID_MAX,
			COORD_MAX, COORD_MIN, 1, 0, 0);
		add_word(COORD_MIN, COORD_MIN, 1, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0, 1, 0, 0);
		add_word(COORD_MIN, COORD_MIN, 1, COORD_MAX, COORD_MAX, 0, 1, 0,
			COORD_MIN, COORD_MAX, 1, 1, 0);
		add_word(COORD_MAX, COORD_MAX, 1, COORD_MIN, COORD_MIN, ID_MAX, 1, 0,
			COORD_MIN, COORD_MAX, 0, 0, 0);
		add_word(COORD_MAX, COORD_MAX, 1, COORD_MIN, COORD_MIN, ID_MAX, 1, 1,
			COORD_MAX, COORD_MIN, 0, 1, 0);
		// Counterclockwise with a previous vertex.
		add_word(0, 0, 1, -U, 0, 3, 1, 10, 0, U, 1, 0, 0);
		add_word(0, 0, 1, -U, 0, 3, 1, 11, 0, -U, 1, 0, 0);
		add_word(0, 0, 1, -U, 0, 3, 1, 12, U, 0, 1, 1, 0);

		first_query = 1'b1;
		while (pending_words.size() < 1470) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
			noise = $urandom_range(0, 11) == 0;
			drain = first_query || $urandom_range(0, 39) == 0;
			first_query = 1'b0;
			cx = pick_base();
			cy = pick_base();
			hp = 1'($urandom_range(0, 1));
			px = cx + pick_offset();
			py = cy + pick_offset();
			pid = pick_id();
			ccw = 1'($urandom_range(0, 1));
			for (i = 0; i < len; i++) begin
				is_last = i == len - 1;
				if (noise) begin
					cx = pick_base();
					cy = pick_base();
					px = full_coord();
					py = full_coord();
					hp = 1'($urandom_range(0, 1));
					pid = pick_id();
					ccw = 1'($urandom_range(0, 1));
					is_last = $urandom_range(0, 3) == 0;
				end
				add_word(cx, cy, hp, px, py, pid, $urandom_range(0, 11) != 0,
					($urandom_range(0, 5) == 0) ? pid : pick_id(),
					cx + pick_offset(), cy + pick_offset(), ccw, is_last, drain && i == 0);
			end
		end
		words_total = pending_words.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_accepted < words_total || expected_picks.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (!mismatch_seen)
			$display("** planar_turn_neighbor_select_core: PASSED **");
		else
			$display("** planar_turn_neighbor_select_core: FAILED **");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("** planar_turn_neighbor_select_core: FAILED **");
		$finish;
	end

endmodule
